@@ rtl/pfe_pkg.sv @@
// shared types, codes and sizes of the postfix expression evaluator
`default_nettype none

package pfe_pkg;

  // operand stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  typedef logic [31:0]       word_t;
  typedef logic [SP_W-1:0]   sp_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [7:0]        char_t;
  typedef logic [2:0]        status_t;

  localparam sp_t SP_FULL = sp_t'(STACK_DEPTH);

  // reset value of the length limit register
  localparam char_t MAX_LEN_RESET = 8'd12;

  // ascii codes
  localparam char_t CH_ZERO  = 8'd48;
  localparam char_t CH_NINE  = 8'd57;
  localparam char_t CH_PLUS  = 8'd43;
  localparam char_t CH_MINUS = 8'd45;
  localparam char_t CH_STAR  = 8'd42;
  localparam char_t CH_SLASH = 8'd47;
  localparam char_t CH_CARET = 8'd94;

  // result status codes
  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_DONE       = 3'd1;
  localparam status_t ST_OVERFLOW   = 3'd2;
  localparam status_t ST_UNDERFLOW  = 3'd3;
  localparam status_t ST_INVALID    = 3'd4;
  localparam status_t ST_INCOMPLETE = 3'd5;
  localparam status_t ST_TOO_LONG   = 3'd6;
  localparam status_t ST_DIV_ZERO   = 3'd7;

  // arithmetic operations
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_POW
  } op_t;

  // control toward the arithmetic unit
  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  // status back from the arithmetic unit
  typedef struct packed {
    logic done;
    logic dz;
  } alu_rsp_t;

endpackage

`default_nettype wire

@@ rtl/pfe_stack_ram.sv @@
// operand stack memory, one write port and one registered read port
`default_nettype none

module pfe_stack_ram (
  input  wire            clk,
  input  wire            wr_en,
  input  pfe_pkg::addr_t wr_addr,
  input  pfe_pkg::word_t wr_data,
  input  pfe_pkg::addr_t rd_addr,
  output pfe_pkg::word_t rd_data
);
  import pfe_pkg::*;

  word_t mem [STACK_DEPTH];
  word_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/pfe_alu.sv @@
// shared arithmetic unit: add, subtract, multiply, iterative divide and power
`default_nettype none

module pfe_alu (
  input  wire               clk,
  input  wire               rst_n,
  input  pfe_pkg::alu_req_t req,
  input  pfe_pkg::word_t    opa,
  input  pfe_pkg::word_t    opb,
  output pfe_pkg::alu_rsp_t rsp,
  output pfe_pkg::word_t    result
);
  import pfe_pkg::*;

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_DIV  = 2'd1;
  localparam logic [1:0] A_POW  = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic       done_r, done_nxt;
  logic       dz_r, dz_nxt;
  word_t      res_r, res_nxt;
  word_t      acc_r, acc_nxt;     // power accumulator or division remainder
  word_t      base_r, base_nxt;   // power base or divisor magnitude
  word_t      exp_r, exp_nxt;     // power exponent or dividend / quotient shifter
  logic [4:0] cnt_r, cnt_nxt;
  logic       phase_r, phase_nxt;
  logic       neg_r, neg_nxt;

  word_t       mul_x, mul_y, prod;
  logic [32:0] shifted, diff;
  logic        ge;
  word_t       quo_next;

  // multiplier operand select
  always_comb begin
    mul_x = opa;
    mul_y = opb;
    if (st_r == A_POW) begin
      mul_x = phase_r ? base_r : acc_r;
      mul_y = base_r;
    end
  end

  // single shared multiplier, low 32 bits of the product
  assign prod = mul_x * mul_y;

  // one restoring division step
  assign shifted  = {acc_r, exp_r[31]};
  assign diff     = shifted - {1'b0, base_r};
  assign ge       = (shifted >= {1'b0, base_r});
  assign quo_next = {exp_r[30:0], ge};

  // sequencing of the unit
  always_comb begin
    st_nxt    = st_r;
    done_nxt  = 1'b0;
    dz_nxt    = dz_r;
    res_nxt   = res_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    exp_nxt   = exp_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    unique case (st_r)
      A_IDLE: begin
        if (req.start) begin
          dz_nxt = 1'b0;
          unique case (req.op)
            OP_ADD: begin
              res_nxt  = opa + opb;
              done_nxt = 1'b1;
            end
            OP_SUB: begin
              res_nxt  = opa - opb;
              done_nxt = 1'b1;
            end
            OP_MUL: begin
              res_nxt  = prod;
              done_nxt = 1'b1;
            end
            OP_DIV: begin
              if (opb == '0) begin
                res_nxt  = '0;
                dz_nxt   = 1'b1;
                done_nxt = 1'b1;
              end else begin
                acc_nxt  = '0;
                exp_nxt  = opa[31] ? (32'd0 - opa) : opa;
                base_nxt = opb[31] ? (32'd0 - opb) : opb;
                neg_nxt  = opa[31] ^ opb[31];
                cnt_nxt  = 5'd31;
                st_nxt   = A_DIV;
              end
            end
            OP_POW: begin
              if (!opb[31]) begin
                acc_nxt   = 32'd1;
                base_nxt  = opa;
                exp_nxt   = opb;
                phase_nxt = 1'b0;
                st_nxt    = A_POW;
              end else begin
                // negative exponent: only a unit base keeps a nonzero result
                done_nxt = 1'b1;
                if (opa == '0) begin
                  res_nxt = '0;
                  dz_nxt  = 1'b1;
                end else if (opa == 32'd1) begin
                  res_nxt = 32'd1;
                end else if (opa == '1) begin
                  res_nxt = opb[0] ? '1 : 32'd1;
                end else begin
                  res_nxt = '0;
                end
              end
            end
            default: begin
              res_nxt  = '0;
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      A_DIV: begin
        acc_nxt = ge ? diff[31:0] : shifted[31:0];
        exp_nxt = quo_next;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          res_nxt  = neg_r ? (32'd0 - quo_next) : quo_next;
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end
      end
      A_POW: begin
        if (exp_r == '0) begin
          res_nxt  = acc_r;
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end else if (!phase_r) begin
          if (exp_r[0]) begin
            acc_nxt = prod;
          end
          phase_nxt = 1'b1;
        end else begin
          base_nxt  = prod;
          exp_nxt   = {1'b0, exp_r[31:1]};
          phase_nxt = 1'b0;
        end
      end
      default: begin
        st_nxt = A_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    dz_r    <= dz_nxt;
    res_r   <= res_nxt;
    acc_r   <= acc_nxt;
    base_r  <= base_nxt;
    exp_r   <= exp_nxt;
    cnt_r   <= cnt_nxt;
    phase_r <= phase_nxt;
    neg_r   <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.dz   = dz_r;
  assign result   = res_r;

endmodule

`default_nettype wire

@@ rtl/postfix_expression_evaluator.sv @@
// top level of the postfix expression evaluator: sequencer, stack control and output register
//
//  channel   direction  ports                                           transaction when
//  in        input      in_valid, in_stall, in_symbol, in_end_marker    in_valid && !in_stall
//  out       output     out_valid, out_stall, out_value, out_status,    out_valid && !out_stall
//                       out_finished
//  cfg       input      cfg_wr_en, cfg_wr_data (max_length)             cfg_wr_en
//
//  a digit, the end marker or an erroring character passes the decode and output states on its way to the output
//  register; add, subtract and multiply also pass the read and arithmetic states
//  divide runs through the one-bit-per-cycle divider in the shared unit
//  power repeats a conditional multiply and a square for each significant exponent bit, one multiplier pass each
//  the stack memory is not cleared by reset; the stack pointer alone marks valid entries
//  in_stall is high while a character is in progress; a stalled result does not block the
//  next character until that character's own result is ready
`default_nettype none

module postfix_expression_evaluator (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  pfe_pkg::char_t        in_symbol,
  input  wire                   in_end_marker,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic signed [31:0]    out_value,
  output pfe_pkg::status_t      out_status,
  output logic                  out_finished,
  input  wire                   cfg_wr_en,
  input  pfe_pkg::char_t        cfg_wr_data
);
  import pfe_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_ALU    = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0] state_r, state_nxt;
  sp_t        sp_r, sp_nxt;
  char_t      count_r, count_nxt;
  status_t    err_r, err_nxt;
  char_t      max_len_r;
  logic       out_valid_r, out_valid_nxt;

  char_t      sym_r;
  logic       end_r;
  word_t      top_r, top_nxt;
  op_t        op_r, op_nxt;
  word_t      res_value_r, res_value_nxt;
  status_t    res_status_r, res_status_nxt;
  logic       res_fin_r, res_fin_nxt;

  word_t      out_value_r;
  status_t    out_status_r;
  logic       out_fin_r;

  sp_t        sp_m1, sp_m2;
  logic       mem_we;
  word_t      mem_rdata;
  alu_req_t   alu_req;
  alu_rsp_t   alu_rsp;
  word_t      alu_result;
  logic       is_digit, is_op, out_free, out_load;
  op_t        sym_op;

  assign sp_m1 = sp_r - sp_t'(1);
  assign sp_m2 = sp_r - sp_t'(2);

  // operand stack below the top entry
  pfe_stack_ram u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (sp_m1[ADDR_W-1:0]),
    .wr_data (top_r),
    .rd_addr (sp_m2[ADDR_W-1:0]),
    .rd_data (mem_rdata)
  );

  // shared arithmetic
  pfe_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opa    (mem_rdata),
    .opb    (top_r),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  // character classification
  always_comb begin
    is_digit = (sym_r >= CH_ZERO) && (sym_r <= CH_NINE);
    is_op    = 1'b1;
    sym_op   = OP_ADD;
    unique case (sym_r)
      CH_PLUS:  sym_op = OP_ADD;
      CH_MINUS: sym_op = OP_SUB;
      CH_STAR:  sym_op = OP_MUL;
      CH_SLASH: sym_op = OP_DIV;
      CH_CARET: sym_op = OP_POW;
      default:  is_op  = 1'b0;
    endcase
  end

  assign out_free    = !out_valid_r || !out_stall;
  assign out_load    = (state_r == S_OUT) && out_free;
  assign alu_req.start = (state_r == S_READ);
  assign alu_req.op    = op_r;

  // sequencer and stack control
  always_comb begin
    state_nxt      = state_r;
    sp_nxt         = sp_r;
    count_nxt      = count_r;
    err_nxt        = err_r;
    top_nxt        = top_r;
    op_nxt         = op_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    res_fin_nxt    = res_fin_r;
    mem_we         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_value_nxt = '0;
        res_fin_nxt   = 1'b0;
        state_nxt     = S_OUT;
        if (end_r) begin
          // close the expression and clear the stack pointer, length count and error
          res_fin_nxt = 1'b1;
          if (err_r != ST_OK) begin
            res_status_nxt = err_r;
          end else if (sp_r == '0) begin
            res_status_nxt = ST_UNDERFLOW;
          end else begin
            res_value_nxt  = top_r;
            res_status_nxt = (sp_r != sp_t'(1)) ? ST_INCOMPLETE : ST_DONE;
          end
          sp_nxt    = '0;
          count_nxt = '0;
          err_nxt   = ST_OK;
        end else if (err_r != ST_OK) begin
          res_status_nxt = err_r;
        end else if (count_r >= max_len_r) begin
          res_status_nxt = ST_TOO_LONG;
          err_nxt        = ST_TOO_LONG;
        end else begin
          count_nxt = count_r + 8'd1;
          if (is_digit) begin
            if (sp_r >= SP_FULL) begin
              res_status_nxt = ST_OVERFLOW;
              err_nxt        = ST_OVERFLOW;
            end else begin
              // spill the old top into memory, new digit becomes the top
              mem_we         = (sp_r != '0);
              top_nxt        = 32'(sym_r - CH_ZERO);
              sp_nxt         = sp_r + sp_t'(1);
              res_value_nxt  = 32'(sym_r - CH_ZERO);
              res_status_nxt = ST_OK;
            end
          end else if (is_op) begin
            if (sp_r < sp_t'(2)) begin
              res_status_nxt = ST_UNDERFLOW;
              err_nxt        = ST_UNDERFLOW;
            end else begin
              // first (left) operand is read from memory this cycle
              op_nxt    = sym_op;
              state_nxt = S_READ;
            end
          end else begin
            res_status_nxt = ST_INVALID;
            err_nxt        = ST_INVALID;
          end
        end
      end
      S_READ: begin
        state_nxt = S_ALU;
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          state_nxt = S_OUT;
          if (alu_rsp.dz) begin
            res_value_nxt  = '0;
            res_status_nxt = ST_DIV_ZERO;
            err_nxt        = ST_DIV_ZERO;
          end else begin
            top_nxt        = alu_result;
            sp_nxt         = sp_m1;
            res_value_nxt  = alu_result;
            res_status_nxt = ST_OK;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      count_r     <= '0;
      err_r       <= ST_OK;
      max_len_r   <= MAX_LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      sym_r <= in_symbol;
      end_r <= in_end_marker;
    end
    top_r        <= top_nxt;
    op_r         <= op_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    res_fin_r    <= res_fin_nxt;
    if (out_load) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
      out_fin_r    <= res_fin_r;
    end
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_value    = $signed(out_value_r);
  assign out_status   = out_status_r;
  assign out_finished = out_fin_r;

  // stack pointer never passes the stack depth
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_FULL)
    else $error("stack pointer beyond depth");

  // an operator only reaches the memory read with two operands present
  a_read_two: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> sp_r >= sp_t'(2))
    else $error("operator issued with fewer than two operands");

  // the arithmetic unit only answers while the sequencer waits for it
  a_alu_done: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> state_r == S_ALU)
    else $error("unexpected arithmetic completion");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK && out_status_r != ST_DONE &&
    out_status_r != ST_INCOMPLETE |-> out_value_r == '0)
    else $error("error result with nonzero value");

  // an arithmetic start follows an operator decode
  a_start_src: assert property (@(posedge clk) disable iff (!rst_n)
    alu_req.start |-> $past(state_r) == S_DECODE)
    else $error("arithmetic start without decode");

endmodule

`default_nettype wire
